[hw/rtl/b64d_pkg.sv]
package b64d_pkg;

   // largest decoded byte count a destination buffer can hold
   localparam int unsigned MAX_BYTES = 4096;
   localparam int unsigned CNT_W     = 13;
   localparam int unsigned OFFSET_W  = 12;
   localparam int unsigned CAP_W     = 13;

   localparam logic [7:0] PAD_CODE = 8'h3d;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_BAD_LEN  = 2'd2,
      STATUS_OVER_CAP = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_REVERSE  = 1'd0,
      CSR_CAPACITY = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                byte_valid;
      logic [7:0]          data_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                from_end;
      logic                done_res;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic             reverse_placement;
      logic [CAP_W-1:0] output_capacity;
   } cfg_type;

   // {valid, sextet}; valid low for codes outside the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2b) begin
         r = {1'b1, 6'h3e};
      end else if (c == 8'h2f) begin
         r = {1'b1, 6'h3f};
      end
      return r;
   endfunction

endpackage

[hw/rtl/b64d_step.sv]
module b64d_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  b64d_pkg::req_type item,
   input  b64d_pkg::cfg_type cfg,
   output b64d_pkg::rsp_type result
);

   logic [1:0]                 pos_ff, pos_in;
   logic [5:0]                 prev_ff, prev_in;
   logic                       pad_ff, pad_in;
   logic                       ended_ff, ended_in;
   logic                       full_ff, full_in;
   logic [b64d_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       char_err_ff, char_err_in;
   logic                       cap_err_ff, cap_err_in;

   logic [6:0]                 lookup;
   logic [5:0]                 v;
   logic                       v_ok;
   logic                       is_pad;
   logic                       bad;
   logic                       emit;
   logic [7:0]                 dbyte;
   logic [b64d_pkg::OFFSET_W-1:0] offset;
   logic [b64d_pkg::CAP_W-1:0] cap_eff;
   logic [1:0]                 status;

   assign lookup = b64d_pkg::sextet_of(item.char_code);
   assign v_ok   = lookup[6];
   assign v      = lookup[5:0];
   assign is_pad = (item.char_code == b64d_pkg::PAD_CODE);

   assign cap_eff = (cfg.output_capacity > b64d_pkg::CAP_W'(b64d_pkg::MAX_BYTES)) ?
                    b64d_pkg::CAP_W'(b64d_pkg::MAX_BYTES) : cfg.output_capacity;

   always_comb begin
      pos_in      = pos_ff + 2'd1;
      prev_in     = prev_ff;
      pad_in      = pad_ff;
      ended_in    = ended_ff;
      full_in     = full_ff | (pos_ff == 2'd3);
      cnt_in      = cnt_ff;
      char_err_in = char_err_ff;
      cap_err_in  = cap_err_ff;
      bad         = 1'b0;
      emit        = 1'b0;
      dbyte       = 8'd0;
      offset      = '0;

      if (!ended_ff) begin
         case (pos_ff)
            2'd0: begin
               if (!v_ok) bad = 1'b1;
               else prev_in = v;
            end
            2'd1: begin
               if (!v_ok) bad = 1'b1;
               else begin
                  dbyte   = {prev_ff, v[5:4]};
                  emit    = 1'b1;
                  prev_in = v;
               end
            end
            2'd2: begin
               if (is_pad) pad_in = 1'b1;
               else if (!v_ok) bad = 1'b1;
               else begin
                  dbyte   = {prev_ff[3:0], v[5:2]};
                  emit    = 1'b1;
                  prev_in = v;
               end
            end
            default: begin
               if (is_pad) ended_in = 1'b1;
               else if (pad_ff || !v_ok) bad = 1'b1;
               else begin
                  dbyte   = {prev_ff[1:0], v};
                  emit    = 1'b1;
                  prev_in = v;
               end
            end
         endcase
         if (bad) begin
            char_err_in = 1'b1;
            ended_in    = 1'b1;
         end
         if (emit) begin
            // a byte past the buffer end is dropped and ends decoding
            if (cnt_ff >= cap_eff) begin
               cap_err_in = 1'b1;
               ended_in   = 1'b1;
               emit       = 1'b0;
               dbyte      = 8'd0;
            end else begin
               offset = cnt_ff[b64d_pkg::OFFSET_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end

      if (item.last_char && !(pos_in == 2'd0 && full_in)) status = b64d_pkg::STATUS_BAD_LEN;
      else if (cap_err_in) status = b64d_pkg::STATUS_OVER_CAP;
      else if (char_err_in) status = b64d_pkg::STATUS_BAD_CHAR;
      else status = b64d_pkg::STATUS_OK;

      // last character closes the text: next one starts fresh
      if (item.last_char) begin
         pos_in      = 2'd0;
         prev_in     = 6'd0;
         pad_in      = 1'b0;
         ended_in    = 1'b0;
         full_in     = 1'b0;
         cnt_in      = '0;
         char_err_in = 1'b0;
         cap_err_in  = 1'b0;
      end
   end

   always_comb begin
      result.byte_valid  = emit;
      result.data_byte   = dbyte;
      result.byte_offset = offset;
      result.from_end    = cfg.reverse_placement;
      result.done_res    = item.last_char;
      result.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 2'd0;
         prev_ff     <= 6'd0;
         pad_ff      <= 1'b0;
         ended_ff    <= 1'b0;
         full_ff     <= 1'b0;
         cnt_ff      <= '0;
         char_err_ff <= 1'b0;
         cap_err_ff  <= 1'b0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         prev_ff     <= prev_in;
         pad_ff      <= pad_in;
         ended_ff    <= ended_in;
         full_ff     <= full_in;
         cnt_ff      <= cnt_in;
         char_err_ff <= char_err_in;
         cap_err_ff  <= cap_err_in;
      end
   end

   a_no_byte_after_end: assert property (@(posedge clock) disable iff (reset)
      result.byte_valid |-> !ended_ff)
      else $error("byte decoded after decoding ended");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= b64d_pkg::CNT_W'(b64d_pkg::MAX_BYTES))
      else $error("byte count beyond buffer limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_char |=> pos_ff == 2'd0 && cnt_ff == '0 && !ended_ff)
      else $error("stream state not cleared after last character");

   a_errors_end: assert property (@(posedge clock) disable iff (reset)
      (char_err_ff || cap_err_ff) |-> ended_ff)
      else $error("error flag set while decoding continues");

endmodule

[hw/rtl/base64_decoder_checked_unit.sv]
// Streaming base64 decoder, one character per transaction.
// req channel: req_data carries the character code and a last-character
//   mark; a transaction completes when req_valid and req_ready are high.
// rsp channel: exactly one result per character: decoded byte (if the
//   character completed one), its offset, the placement copy, the done
//   mark and a sticky status that is final on the last character.
// csr channel: index 0 reverse placement, index 1 output capacity; writes
//   are taken every cycle and must only occur while the block is idle.
// Timing: a character accepted into the input register is decoded there
//   and moves to the result register once that one is free, which raises
//   rsp_valid. Throughput is one character per cycle while the receiver
//   does not stall, set by the single decode step.
// Reset clears the stream state and both pipeline registers; reverse
//   placement returns to 0 and capacity to 4096.
// When the receiver stalls the result register holds, the input register
//   fills, and req_ready drops only once both are occupied.
module base64_decoder_checked_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  b64d_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output b64d_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [b64d_pkg::CAP_W-1:0]    csr_data
);

   logic              in_valid_ff;
   b64d_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   b64d_pkg::rsp_type out_data_ff;
   b64d_pkg::cfg_type cfg_ff;
   b64d_pkg::rsp_type step_result;
   logic              out_free;
   logic              advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   b64d_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reverse_placement <= 1'b0;
         cfg_ff.output_capacity   <= b64d_pkg::CAP_W'(b64d_pkg::MAX_BYTES);
      end else if (csr_valid) begin
         unique case (csr_index)
            b64d_pkg::CSR_REVERSE:  cfg_ff.reverse_placement <= csr_data[0];
            b64d_pkg::CSR_CAPACITY: cfg_ff.output_capacity   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (out_free) out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= step_result;
   end

   a_out_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("result changed while stalled");

   a_ready_when_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      out_free |-> req_ready)
      else $error("input blocked while result side is free");

   a_in_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending character lost");

endmodule
